// File: src/ced_pkg.sv
// Shared constants, token type and helper functions for the edit distance block.
package ced_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_COUNT   = 255;

  localparam int CHW = 16;
  localparam int CW  = 8;
  localparam int LW  = $clog2(MAX_PATTERN + 1);
  localparam int FW  = 2;

  localparam logic [FW-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FW-1:0] FN_APPEND = 2'd1;
  localparam logic [FW-1:0] FN_FEED   = 2'd2;
  localparam logic [FW-1:0] FN_END    = 2'd3;

  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_COUNT);

  typedef struct packed {
    logic           valid;
    logic [FW-1:0]  func;
    logic [CHW-1:0] fc;
    logic [CW-1:0]  left;
    logic [CW-1:0]  diag;
    logic [LW-1:0]  len;
    logic [CW-1:0]  count;
    logic           flag;
    logic [CW-1:0]  score;
  } token_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + CW'(1);
  endfunction

  function automatic logic [CHW-1:0] fold(input logic [CHW-1:0] c);
    return (c >= CHW'(16'h41) && c <= CHW'(16'h5A)) ? c + CHW'(16'h20) : c;
  endfunction

  function automatic logic [CW-1:0] restart_val(input logic [LW-1:0] j);
    return (CW'(j) >= COUNT_MAX) ? COUNT_MAX : CW'(j);
  endfunction

endpackage

// File: src/ced_in_if.sv
// Request channel: one beat carries a function code and a character.
interface ced_in_if import ced_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [FW-1:0]  func;
  logic [CHW-1:0] character;

  modport source (output valid, func, character, input ready);
  modport sink (input valid, func, character, output ready);
endinterface

// File: src/ced_out_if.sv
// Result channel: one beat carries distance, candidate length and overflow.
interface ced_out_if import ced_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] distance;
  logic [CW-1:0] candidate_length;
  logic          overflow;

  modport source (output valid, distance, candidate_length, overflow, input ready);
  modport sink (input valid, distance, candidate_length, overflow, output ready);
endinterface

// File: src/ced_cell.sv
// One pattern cell: holds a pattern character and its row entry, passes the token on.
module ced_cell import ced_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [LW-1:0] idx,
  input  token_t        tok_in,
  output token_t        tok_out
);

  logic [CW-1:0]  row;
  logic [CHW-1:0] pchar;
  logic [CW-1:0]  ins;
  logic [CW-1:0]  del;
  logic [CW-1:0]  sub;
  logic [CW-1:0]  best;
  token_t         tok_next;

  always_comb begin
    ins  = sat_inc(tok_in.left);
    del  = sat_inc(row);
    sub  = (pchar == tok_in.fc) ? tok_in.diag : sat_inc(tok_in.diag);
    best = del;
    if (ins < best) begin
      best = ins;
    end
    if (sub < best) begin
      best = sub;
    end
    tok_next = tok_in;
    if (tok_in.func == FN_FEED) begin
      tok_next.left = best;
      tok_next.diag = row;
    end
    if (tok_in.func == FN_END && tok_in.len == idx) begin
      tok_next.score = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row           <= restart_val(idx);
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        case (tok_in.func)
          FN_FEED: begin
            row <= best;
          end
          FN_APPEND: begin
            row <= restart_val(idx);
            if ((tok_in.len + LW'(1)) == idx) begin
              pchar <= tok_in.fc;
            end
          end
          default: begin
            row <= restart_val(idx);
          end
        endcase
      end
    end
  end

endmodule

// File: src/case_insensitive_edit_distance_top.sv
// Top level: case-insensitive edit distance over a systolic row of pattern cells.
//
// Usage:
//   req carries one beat per operation: func 0 clears the pattern, func 1
//   appends a pattern character, func 2 feeds a candidate character, func 3
//   ends the candidate. Only func 3 gives a beat on rsp: the edit distance,
//   the candidate length and an overflow flag (pattern characters dropped or
//   a count saturated at 255).
//   Each beat enters the head stage, which holds row entry 0, the candidate
//   count and the pattern length, and then travels one cell per cycle, while
//   the row advances, down a row of MAX_PATTERN cells; cell j holds pattern
//   character j and row entry j. The result of an end beat passes the head
//   register and every cell before the rsp register takes it. Throughput is
//   one req beat per cycle while req.ready is high, any mix of functions,
//   since the beats follow one another through the cells in order.
//   If rsp stalls with a result waiting, the whole row holds only when a
//   further end beat reaches the last cell; req.ready then drops.
//   Reset (rst, synchronous) empties the pattern, restarts the row at
//   0..32 and clears the flag and all beats in flight.
module case_insensitive_edit_distance_top import ced_pkg::*; (
  input logic      clk,
  input logic      rst,
  ced_in_if.sink   req,
  ced_out_if.source rsp
);

  logic [CW-1:0] row0;
  logic [CW-1:0] count;
  logic [LW-1:0] plen;
  logic          flag;
  logic          advance;
  logic          tail_end;
  token_t        tok [0:MAX_PATTERN];
  token_t        head_tok;

  assign tail_end  = tok[MAX_PATTERN].valid && tok[MAX_PATTERN].func == FN_END;
  assign advance   = !(tail_end && rsp.valid && !rsp.ready);
  assign req.ready = advance;

  always_comb begin
    head_tok       = '0;
    head_tok.valid = req.valid;
    head_tok.func  = req.func;
    head_tok.fc    = fold(req.character);
    head_tok.left  = sat_inc(row0);
    head_tok.diag  = row0;
    head_tok.len   = plen;
    head_tok.count = count;
    head_tok.flag  = flag;
    head_tok.score = row0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row0         <= '0;
      count        <= '0;
      plen         <= '0;
      flag         <= 1'b0;
      tok[0].valid <= 1'b0;
    end else if (advance) begin
      tok[0] <= head_tok;
      if (req.valid) begin
        case (req.func)
          FN_CLEAR: begin
            plen  <= '0;
            flag  <= 1'b0;
            row0  <= '0;
            count <= '0;
          end
          FN_APPEND: begin
            if (plen < LW'(MAX_PATTERN)) begin
              plen <= plen + LW'(1);
            end else begin
              flag <= 1'b1;
            end
            row0  <= '0;
            count <= '0;
          end
          FN_FEED: begin
            row0  <= sat_inc(row0);
            count <= sat_inc(count);
          end
          default: begin
            row0  <= '0;
            count <= '0;
          end
        endcase
      end
    end
  end

  for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_cell
    ced_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .idx     (LW'(i)),
      .tok_in  (tok[i-1]),
      .tok_out (tok[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance && tail_end) begin
      rsp.valid            <= 1'b1;
      rsp.distance         <= tok[MAX_PATTERN].score;
      rsp.candidate_length <= tok[MAX_PATTERN].count;
      rsp.overflow         <= tok[MAX_PATTERN].flag
                              || tok[MAX_PATTERN].score >= COUNT_MAX
                              || tok[MAX_PATTERN].count >= COUNT_MAX;
    end else if (rsp.valid && rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

// File: src/ced_checker.sv
// Port-level checks for the edit distance block, bound to the top level.
module ced_checker import ced_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input logic [CW-1:0] rsp_distance,
  input logic [CW-1:0] rsp_candidate_length,
  input logic          rsp_overflow
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
      && $stable(rsp_candidate_length) && $stable(rsp_overflow))
    else $error("stalled result beat changed");

  a_dist_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_distance == COUNT_MAX |-> rsp_overflow)
    else $error("saturated distance without overflow");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_candidate_length == COUNT_MAX |-> rsp_overflow)
    else $error("saturated candidate length without overflow");

endmodule

bind case_insensitive_edit_distance_top ced_checker u_ced_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_distance         (rsp.distance),
  .rsp_candidate_length (rsp.candidate_length),
  .rsp_overflow         (rsp.overflow)
);

// File: test/tb_case_insensitive_edit_distance_top.sv
// Testbench for the case-insensitive edit distance block: random and directed beats, scoreboard.
`timescale 1ns / 100ps

module tb_case_insensitive_edit_distance_top import ced_pkg::*; ();

  localparam int PHASE_BEATS    = 617;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 45;

  typedef struct packed {
    logic [FW-1:0]  func;
    logic [CHW-1:0] ch;
  } beat_t;

  typedef struct packed {
    logic [CW-1:0] distance;
    logic [CW-1:0] cand_len;
    logic          overflow;
  } score_t;

  logic clk;
  logic rst;

  ced_in_if  req();
  ced_out_if rsp();

  case_insensitive_edit_distance_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  beat_t  queued_beats[$];
  score_t pending_scores[$];
  beat_t  beat_on_bus;

  int phase;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_added;
  int mismatches;
  int hold_left;
  bit long_hold_done;
  int quiet_cycles;

  // predictor state
  logic [CHW-1:0] pattern_store [MAX_PATTERN];
  int             pattern_len;
  int             cost [MAX_PATTERN + 1];
  int             cand_count;
  bit             dropped_flag;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CHW-1:0] to_lower(logic [CHW-1:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) begin
      return c + 16'h0020;
    end
    return c;
  endfunction

  function automatic int bump(int v);
    return (v >= MAX_COUNT) ? MAX_COUNT : v + 1;
  endfunction

  function automatic void restart_cost();
    for (int j = 0; j <= MAX_PATTERN; j++) begin
      cost[j] = (j > MAX_COUNT) ? MAX_COUNT : j;
    end
    cand_count = 0;
  endfunction

  function automatic void advance_distance(beat_t b);
    int     diag;
    int     left;
    int     up;
    int     best;
    int     ins;
    int     sub;
    score_t s;
    case (b.func)
      FN_CLEAR: begin
        pattern_len  = 0;
        dropped_flag = 1'b0;
        restart_cost();
      end
      FN_APPEND: begin
        if (pattern_len < MAX_PATTERN) begin
          pattern_store[pattern_len] = b.ch;
          pattern_len++;
        end else begin
          dropped_flag = 1'b1;
        end
        restart_cost();
      end
      FN_FEED: begin
        diag    = cost[0];
        left    = bump(cost[0]);
        cost[0] = left;
        for (int j = 1; j <= pattern_len; j++) begin
          up   = cost[j];
          best = bump(up);
          ins  = bump(left);
          sub  = (to_lower(pattern_store[j-1]) == to_lower(b.ch)) ? diag : bump(diag);
          if (ins < best) best = ins;
          if (sub < best) best = sub;
          diag    = up;
          cost[j] = best;
          left    = best;
        end
        cand_count = bump(cand_count);
      end
      default: begin
        s.distance = CW'(cost[pattern_len]);
        s.cand_len = CW'(cand_count);
        s.overflow = dropped_flag || cost[pattern_len] >= MAX_COUNT || cand_count >= MAX_COUNT;
        pending_scores.push_back(s);
        restart_cost();
      end
    endcase
  endfunction

  function automatic void queue_beat(logic [FW-1:0] f, logic [CHW-1:0] c);
    beat_t b;
    b.func = f;
    b.ch   = c;
    queued_beats.push_back(b);
    beats_added++;
  endfunction

  function automatic logic [CHW-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + 16'($urandom_range(0, 3));
    end
    if (r < 7) begin
      case ($urandom_range(0, 7))
        0: return 16'h0040;
        1: return 16'h0041;
        2: return 16'h005A;
        3: return 16'h005B;
        4: return 16'h0060;
        5: return 16'h0061;
        6: return 16'h007A;
        default: return 16'h007B;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void flag_mismatch(string what, int want, int got);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
    mismatches++;
  endfunction

  function automatic void add_directed();
    queue_beat(FN_END, 16'hFFFF);
    queue_beat(FN_FEED, 16'h0078);
    queue_beat(FN_FEED, 16'hFFFF);
    queue_beat(FN_END, 16'h0000);
    queue_beat(FN_APPEND, 16'h0041);
    queue_beat(FN_APPEND, 16'h005B);
    queue_beat(FN_APPEND, 16'h0000);
    queue_beat(FN_END, 16'h5555);
    queue_beat(FN_FEED, 16'h0061);
    queue_beat(FN_FEED, 16'h007B);
    queue_beat(FN_FEED, 16'h0000);
    queue_beat(FN_END, 16'hAAAA);
    queue_beat(FN_CLEAR, 16'hFFFF);
    queue_beat(FN_APPEND, 16'h007A);
    queue_beat(FN_APPEND, 16'h0040);
    queue_beat(FN_FEED, 16'h005A);
    queue_beat(FN_FEED, 16'h0060);
    queue_beat(FN_END, 16'h0000);
    queue_beat(FN_FEED, 16'h0071);
    queue_beat(FN_APPEND, 16'h0051);
    queue_beat(FN_FEED, 16'h0071);
    queue_beat(FN_END, 16'h0000);
    queue_beat(FN_CLEAR, 16'h0000);
    queue_beat(FN_END, 16'hFFFF);
  endfunction

  // one candidate long enough to reach or approach saturation
  function automatic void add_long_candidate(int which);
    int n;
    queue_beat(FN_CLEAR, pick_char());
    if (which == 0) begin
      n = MAX_COUNT;
    end else if (which == 1) begin
      n = MAX_COUNT - 1;
    end else begin
      repeat ($urandom_range(1, 6)) queue_beat(FN_APPEND, pick_char());
      n = $urandom_range(MAX_COUNT + 1, MAX_COUNT + 45);
    end
    repeat (n) queue_beat(FN_FEED, pick_char());
    queue_beat(FN_END, pick_char());
  endfunction

  function automatic void add_session();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 3)) begin
        queue_beat(FW'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      end
      return;
    end
    if (r < 40) begin
      if ($urandom_range(0, 4) != 0) queue_beat(FN_CLEAR, pick_char());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
      repeat (n) queue_beat(FN_APPEND, pick_char());
    end
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 10)) queue_beat(FN_FEED, pick_char());
      if ($urandom_range(0, 19) == 0) begin
        queue_beat(FN_APPEND, pick_char());
      end else begin
        queue_beat(FN_END, pick_char());
      end
    end
  endfunction

  // sender
  always @(posedge clk) begin : drive_beat
    beat_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        advance_distance(beat_on_bus);
      end
      if (!req.valid || req.ready) begin
        if (queued_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt           = queued_beats.pop_front();
          beat_on_bus   = nxt;
          req.valid     <= 1'b1;
          req.func      <= nxt.func;
          req.character <= nxt.ch;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin : collect_beat
    score_t want;
    if (rst) begin
      rsp.ready      <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_scores.size() == 0) begin
          if (mismatches < 10) begin
            $display("result with nothing expected: distance %0d, length %0d, overflow %0d",
                     rsp.distance, rsp.candidate_length, rsp.overflow);
          end
          mismatches++;
        end else begin
          want = pending_scores.pop_front();
          if (rsp.distance !== want.distance) begin
            flag_mismatch("distance", want.distance, rsp.distance);
          end
          if (rsp.candidate_length !== want.cand_len) begin
            flag_mismatch("candidate_length", want.cand_len, rsp.candidate_length);
          end
          if (rsp.overflow !== want.overflow) begin
            flag_mismatch("overflow", want.overflow, rsp.overflow);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else if (phase == 2 && !long_hold_done) begin
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
        rsp.ready      <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.func      = FN_CLEAR;
    req.character = '0;
    rsp.ready     = 1'b0;
    phase         = 0;
    send_idle_pct = 11;
    recv_idle_pct = 84;
    beats_added   = 0;
    mismatches    = 0;
    pattern_len   = 0;
    dropped_flag  = 1'b0;
    restart_cost();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < 3; p++) begin
      phase         = p;
      send_idle_pct = (p == 0) ? 11 : (p == 1) ? 84 : 0;
      recv_idle_pct = (p == 0) ? 84 : (p == 1) ? 11 : 0;
      beats_added   = 0;
      if (p == 0) add_directed();
      add_long_candidate(p);
      while (beats_added < PHASE_BEATS) add_session();
      while (queued_beats.size() != 0) @(negedge clk);
    end

    while (req.valid) @(negedge clk);
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
